>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CSC_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled in reset
`define CSC_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

>>> src/csc_pkg.sv
package csc_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = 16;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 5;
  localparam int CFG_RESET  = 16;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 16;

  typedef logic [FRAME_W-1:0] frame_idx_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [CNT_W-1:0]   frame_cnt_t;

  // request from the sequencer to the frame table
  typedef struct packed {
    frame_idx_t idx;
    page_t      wdata;
    logic       set_ref;
    logic       clr_ref;
    logic       fill;
  } tbl_cmd_t;

  // contents of the addressed frame
  typedef struct packed {
    page_t page;
    logic  valid;
    logic  referenced;
  } tbl_stat_t;

  // zero acts as one frame, anything above the table size as the full table
  function automatic frame_cnt_t active_frames(input logic [CFG_W-1:0] cfg);
    frame_cnt_t n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(cfg) > MAX_FRAMES) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

>>> src/clock_second_chance_replacement_unit.sv
// one item at a time: a hit on frame i loads the result once the search reaches frame i,
// a fault compares all n frames, then the hand visits at most n+1 frames (n = frames in use)
// the single page comparator and index stepper walk one frame per cycle, holding at
// the chosen frame while the result register is busy; in_ready returns on result load
// synchronous reset empties all frames, clears the hand and fault total, frames in use = 16
module clock_second_chance_replacement_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csc_pkg::CFG_W-1:0]       frames_in_use,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csc_pkg::PAGE_W-1:0]      page,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [csc_pkg::INDEX_W-1:0]     frame_index,
  output logic                            evicted_valid,
  output logic [csc_pkg::PAGE_W-1:0]      evicted_page,
  output logic [csc_pkg::COUNT_W-1:0]     fault_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP
  } state_t;

  state_t                       state;
  logic [csc_pkg::CFG_W-1:0]    frame_limit;
  csc_pkg::page_t               key;
  csc_pkg::frame_idx_t          idx;
  csc_pkg::frame_idx_t          hand;
  logic [csc_pkg::COUNT_W-1:0]  fault_total;

  csc_pkg::tbl_cmd_t            cmd;
  csc_pkg::tbl_stat_t           stat;
  csc_pkg::frame_cnt_t          n_act;
  csc_pkg::frame_cnt_t          idx_inc;
  csc_pkg::frame_idx_t          idx_wrap;
  csc_pkg::frame_idx_t          sweep_start;
  logic                         match;
  logic                         idx_last;
  logic                         out_free;
  logic                         skip;
  logic                         res_load;

  csc_frame_table u_table (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign n_act       = csc_pkg::active_frames(frame_limit);
  assign idx_inc     = csc_pkg::CNT_W'(idx) + csc_pkg::CNT_W'(1);
  assign idx_last    = (idx_inc == n_act);
  assign idx_wrap    = (idx_inc < n_act) ? csc_pkg::FRAME_W'(idx_inc) : '0;
  // hand left beyond a shrunk frame count restarts at frame 0
  assign sweep_start = (csc_pkg::CNT_W'(hand) < n_act) ? hand : '0;
  assign match       = stat.valid && (stat.page == key);
  assign skip        = stat.valid && stat.referenced;
  assign out_free    = !out_valid || out_ready;
  assign res_load    = out_free && (((state == ST_SEARCH) && match) ||
                                    ((state == ST_SWEEP) && !skip));

  always_comb begin
    cmd         = '0;
    cmd.idx     = idx;
    cmd.wdata   = key;
    unique case (state)
      ST_SEARCH: begin
        cmd.set_ref = match && out_free;
      end
      ST_SWEEP: begin
        cmd.clr_ref = skip;
        cmd.fill    = !skip && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_limit <= csc_pkg::CFG_W'(csc_pkg::CFG_RESET);
      hand        <= '0;
      fault_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_limit <= frames_in_use;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key   <= page;
            idx   <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (match) begin
            // result register busy: hold here, the compare repeats harmlessly
            if (out_free) begin
              hit           <= 1'b1;
              frame_index   <= csc_pkg::INDEX_W'(idx);
              evicted_valid <= 1'b0;
              evicted_page  <= '0;
              fault_count   <= fault_total;
              state         <= ST_IDLE;
            end
          end else if (idx_last) begin
            if (fault_total != '1) begin
              fault_total <= fault_total + 1'b1;
            end
            idx   <= sweep_start;
            state <= ST_SWEEP;
          end else begin
            idx <= csc_pkg::FRAME_W'(idx_inc);
          end
        end
        ST_SWEEP: begin
          if (skip) begin
            idx <= idx_wrap;
          end else if (out_free) begin
            hit           <= 1'b0;
            frame_index   <= csc_pkg::INDEX_W'(idx);
            evicted_valid <= stat.valid;
            evicted_page  <= stat.valid ? stat.page : '0;
            fault_count   <= fault_total;
            hand          <= idx_wrap;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/csc_frame_table.sv
module csc_frame_table (
  input  logic                clk,
  input  logic                rst,
  input  csc_pkg::tbl_cmd_t   cmd,
  output csc_pkg::tbl_stat_t  stat
);

  csc_pkg::page_t                page_mem [csc_pkg::MAX_FRAMES];
  logic [csc_pkg::MAX_FRAMES-1:0] valid_bits;
  logic [csc_pkg::MAX_FRAMES-1:0] ref_bits;

  // page entries are only read behind their valid bit, so no reset
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      page_mem[cmd.idx] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      ref_bits   <= '0;
    end else begin
      if (cmd.fill) begin
        valid_bits[cmd.idx] <= 1'b1;
        ref_bits[cmd.idx]   <= 1'b1;
      end else if (cmd.set_ref) begin
        ref_bits[cmd.idx] <= 1'b1;
      end else if (cmd.clr_ref) begin
        ref_bits[cmd.idx] <= 1'b0;
      end
    end
  end

  assign stat.page       = page_mem[cmd.idx];
  assign stat.valid      = valid_bits[cmd.idx];
  assign stat.referenced = ref_bits[cmd.idx];

endmodule

>>> src/csc_checker.sv
`include "assert_macros.svh"

module csc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic [csc_pkg::INDEX_W-1:0] frame_index,
  input logic                        evicted_valid,
  input logic [csc_pkg::PAGE_W-1:0]  evicted_page,
  input logic [csc_pkg::COUNT_W-1:0] fault_count
);

  // a transfer in keeps the block busy for at least the next cycle
  `CSC_ASSERT_NXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)
  // a hit never reports an eviction
  `CSC_ASSERT_IMP(a_hit_no_evict, clk, rst, out_valid && hit,
                  !evicted_valid && (evicted_page == '0))
  // a fault has always been counted
  `CSC_ASSERT_IMP(a_fault_counted, clk, rst, out_valid && !hit, fault_count != '0)
  // stalled result holds
  `CSC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(frame_index) && $stable(fault_count))

endmodule

bind clock_second_chance_replacement_unit csc_checker u_csc_checker (.*);
